// File: src/ccsmt_pkg.sv
// Shared types and constants for the cell statistics table.
// Holds the cell record, operation codes and the empty-cell values.
// No dependencies.
package ccsmt_pkg;

   localparam int OP_W    = 2;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 16;
   localparam int SUM_W   = 48;

   localparam int DEF_ROWS = 64;
   localparam int DEF_COLS = 64;

   localparam logic [OP_W-1:0] OP_ACCUM     = 2'd0;
   localparam logic [OP_W-1:0] OP_READ      = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLR  = 2'd2;

   localparam logic [COUNT_W-1:0]      COUNT_TOP = '1;
   localparam logic signed [SUM_W-1:0] SUM_HI    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO    = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] EMPTY_MIN = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] EMPTY_MAX = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_W-1:0]      count;
      logic signed [SUM_W-1:0] sum;
      logic signed [VAL_W-1:0] min;
      logic signed [VAL_W-1:0] max;
   } cell_type;

   localparam cell_type EMPTY_CELL = '{
      count: '0,
      sum:   '0,
      min:   EMPTY_MIN,
      max:   EMPTY_MAX
   };

endpackage

// File: src/cell_count_sum_min_max_table.sv
// Grid of cells, each keeping a saturating count, saturating sum, min and max.
// Depends on ccsmt_pkg for the cell record, operation codes and empty values.
//
// Usage:
//   Requests arrive on req_* (valid/ready). Operation accumulate adds
//   req_sample_value to the cell at (req_row_index, req_col_index) and gives
//   no response. Read returns the cell's statistics on rsp_*; read-and-clear
//   returns them and empties the cell. Code 3 and accumulates outside the
//   grid are dropped; reads outside the grid return the empty-cell values.
//   A read passes through the modify stage into the output register, where
//   rsp_valid rises. Throughput: one request per cycle while req_ready is
//   high. The table is a synchronous memory with one read and one write port;
//   each request reads its cell at acceptance, accumulates and read-and-clears
//   write it back from the modify stage, and a request accepted as its cell
//   is written takes the written value from a forwarding register.
//   Reset: the table is swept back to the empty state, one cell per cycle
//   through every cell of the grid, with req_ready low throughout.
//   Stall: a response waits in the output register; the next read request
//   holds in the modify stage and req_ready falls until rsp_ready rises.
//   Accumulates keep flowing behind a waiting response while the stage is free.
module cell_count_sum_min_max_table #(
   parameter int ROWS = ccsmt_pkg::DEF_ROWS,
   parameter int COLS = ccsmt_pkg::DEF_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ccsmt_pkg::OP_W-1:0]           req_operation,
   input  logic [ccsmt_pkg::ROW_W-1:0]          req_row_index,
   input  logic [ccsmt_pkg::COL_W-1:0]          req_col_index,
   input  logic signed [ccsmt_pkg::VAL_W-1:0]   req_sample_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ccsmt_pkg::COUNT_W-1:0]        rsp_cell_count,
   output logic signed [ccsmt_pkg::SUM_W-1:0]   rsp_cell_sum,
   output logic signed [ccsmt_pkg::VAL_W-1:0]   rsp_cell_min,
   output logic signed [ccsmt_pkg::VAL_W-1:0]   rsp_cell_max
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

   // table storage
   ccsmt_pkg::cell_type table_mem [CELLS];

   // clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_ptr_ff, clr_ptr_in;

   // modify stage
   logic                                s1_valid_ff, s1_valid_in;
   logic [ccsmt_pkg::OP_W-1:0]          s1_op_ff;
   logic                                s1_inside_ff;
   logic [ADDR_W-1:0]                   s1_addr_ff;
   logic signed [ccsmt_pkg::VAL_W-1:0]  s1_sample_ff;
   ccsmt_pkg::cell_type                 rd_data_ff;
   ccsmt_pkg::cell_type                 fwd_data_ff;
   logic                                fwd_hit_ff;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   ccsmt_pkg::cell_type                 rsp_data_ff;

   logic                                req_accept;
   logic                                req_inside;
   logic [ADDR_W-1:0]                   req_addr;
   logic                                s1_has_rsp;
   logic                                s1_adv;
   logic                                s1_wr_en;
   ccsmt_pkg::cell_type                 cur_cell;
   ccsmt_pkg::cell_type                 acc_cell;
   ccsmt_pkg::cell_type                 wr_cell;
   ccsmt_pkg::cell_type                 rsp_cell;
   logic signed [ccsmt_pkg::SUM_W:0]    sum_wide;

   assign req_inside = (int'(req_row_index) < ROWS) && (int'(req_col_index) < COLS);
   assign req_addr   = ADDR_W'(int'(req_row_index) * COLS + int'(req_col_index));

   assign s1_has_rsp = (s1_op_ff == ccsmt_pkg::OP_READ) ||
                       (s1_op_ff == ccsmt_pkg::OP_READ_CLR);
   assign s1_adv     = !s1_has_rsp || !rsp_valid_ff || rsp_ready;
   assign req_ready  = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;

   // take the value written back as this request was accepted when it hit the same cell
   assign cur_cell = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      sum_wide = {cur_cell.sum[ccsmt_pkg::SUM_W-1], cur_cell.sum} +
                 {{(ccsmt_pkg::SUM_W + 1 - ccsmt_pkg::VAL_W){s1_sample_ff[ccsmt_pkg::VAL_W-1]}},
                  s1_sample_ff};
      acc_cell = cur_cell;
      if (cur_cell.count != ccsmt_pkg::COUNT_TOP) begin
         acc_cell.count = cur_cell.count + 1'b1;
      end
      // clamp when the two top bits disagree
      if (sum_wide[ccsmt_pkg::SUM_W] != sum_wide[ccsmt_pkg::SUM_W-1]) begin
         acc_cell.sum = sum_wide[ccsmt_pkg::SUM_W] ? ccsmt_pkg::SUM_LO : ccsmt_pkg::SUM_HI;
      end else begin
         acc_cell.sum = sum_wide[ccsmt_pkg::SUM_W-1:0];
      end
      if (s1_sample_ff < cur_cell.min) begin
         acc_cell.min = s1_sample_ff;
      end
      if (s1_sample_ff > cur_cell.max) begin
         acc_cell.max = s1_sample_ff;
      end
   end

   always_comb begin
      wr_cell  = acc_cell;
      s1_wr_en = 1'b0;
      case (s1_op_ff)
         ccsmt_pkg::OP_ACCUM: begin
            wr_cell  = acc_cell;
            s1_wr_en = s1_valid_ff && s1_inside_ff;
         end
         ccsmt_pkg::OP_READ_CLR: begin
            wr_cell  = ccsmt_pkg::EMPTY_CELL;
            s1_wr_en = s1_valid_ff && s1_inside_ff && s1_adv;
         end
         default: begin
            wr_cell  = acc_cell;
            s1_wr_en = 1'b0;
         end
      endcase
   end

   assign rsp_cell = s1_inside_ff ? cur_cell : ccsmt_pkg::EMPTY_CELL;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clr_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == LAST_CELL) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_valid_ff && s1_has_rsp && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_ptr_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_ptr_ff   <= clr_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fwd_hit_ff <= s1_wr_en && (s1_addr_ff == req_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= req_operation;
         s1_inside_ff <= req_inside;
         s1_addr_ff   <= req_addr;
         s1_sample_ff <= req_sample_value;
         fwd_data_ff  <= wr_cell;
      end
      if (s1_valid_ff && s1_has_rsp && s1_adv) begin
         rsp_data_ff <= rsp_cell;
      end
   end

   // one write port: sweep writes during clearing, else write back
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         table_mem[clr_ptr_ff] <= ccsmt_pkg::EMPTY_CELL;
      end else if (s1_wr_en) begin
         table_mem[s1_addr_ff] <= wr_cell;
      end
      if (req_accept) begin
         rd_data_ff <= table_mem[req_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_count = rsp_data_ff.count;
   assign rsp_cell_sum   = rsp_data_ff.sum;
   assign rsp_cell_min   = rsp_data_ff.min;
   assign rsp_cell_max   = rsp_data_ff.max;

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_accept && !s1_valid_ff)
      else $error("request taken during clearing sweep");

   a_fwd_follows_write: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_hit_ff) |-> $past(s1_wr_en))
      else $error("forwarding flag set without a write-back");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_has_rsp && s1_adv |=> rsp_valid_ff)
      else $error("completed read left no response");

   a_empty_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.count == '0) |->
         (rsp_data_ff.sum == '0) && (rsp_data_ff.min == ccsmt_pkg::EMPTY_MIN) &&
         (rsp_data_ff.max == ccsmt_pkg::EMPTY_MAX))
      else $error("empty cell returned non-empty statistics");

endmodule

// File: test/cell_stats_checker.sv
`timescale 1ns / 1ps
// Checker for the cell statistics table. It mirrors the grid from accepted
// requests and compares every accepted response with the predicted cell.
// Depends on ccsmt_pkg for widths, operation codes and the empty-cell record.
module cell_stats_checker #(
   parameter int ROWS = ccsmt_pkg::DEF_ROWS,
   parameter int COLS = ccsmt_pkg::DEF_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [ccsmt_pkg::OP_W-1:0]           req_operation,
   input  logic [ccsmt_pkg::ROW_W-1:0]          req_row_index,
   input  logic [ccsmt_pkg::COL_W-1:0]          req_col_index,
   input  logic signed [ccsmt_pkg::VAL_W-1:0]   req_sample_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [ccsmt_pkg::COUNT_W-1:0]        rsp_cell_count,
   input  logic signed [ccsmt_pkg::SUM_W-1:0]   rsp_cell_sum,
   input  logic signed [ccsmt_pkg::VAL_W-1:0]   rsp_cell_min,
   input  logic signed [ccsmt_pkg::VAL_W-1:0]   rsp_cell_max,
   output int                                   fail_count,
   output int                                   stats_pending,
   output int                                   accum_count,
   output int                                   checked_count,
   output int                                   saturated_count
);
   import ccsmt_pkg::*;

   localparam int CELLS = ROWS * COLS;

   cell_type grid [CELLS];
   cell_type stats_due [$];

   task automatic apply_request(input logic [OP_W-1:0]         op,
                                input logic [ROW_W-1:0]        row,
                                input logic [COL_W-1:0]        col,
                                input logic signed [VAL_W-1:0] val);
      int       idx;
      bit       on_grid;
      longint   total;
      cell_type stats;
      on_grid = (int'(row) < ROWS) && (int'(col) < COLS);
      idx     = on_grid ? int'(row) * COLS + int'(col) : 0;
      stats   = grid[idx];
      case (op)
         OP_ACCUM: begin
            if (on_grid) begin
               if (stats.count != COUNT_TOP)
                  stats.count = stats.count + 1'b1;
               total = longint'(stats.sum) + longint'(val);
               // clamp to the 48-bit signed range
               if (total > longint'(SUM_HI))
                  total = longint'(SUM_HI);
               else if (total < longint'(SUM_LO))
                  total = longint'(SUM_LO);
               stats.sum = total[SUM_W-1:0];
               if (val < stats.min)
                  stats.min = val;
               if (val > stats.max)
                  stats.max = val;
               grid[idx] = stats;
               accum_count++;
            end
         end
         OP_READ, OP_READ_CLR: begin
            stats_due.push_back(on_grid ? stats : EMPTY_CELL);
            if (on_grid && op == OP_READ_CLR)
               grid[idx] = EMPTY_CELL;
         end
         default: ;
      endcase
   endtask

   task automatic check_response;
      cell_type want;
      if (stats_due.size() == 0) begin
         $error("response with no read outstanding: count %0d sum %0d",
                rsp_cell_count, rsp_cell_sum);
         fail_count++;
         return;
      end
      want = stats_due.pop_front();
      if (rsp_cell_count !== want.count) begin
         $error("cell_count: expected %0d, got %0d", want.count, rsp_cell_count);
         fail_count++;
      end
      if (rsp_cell_sum !== want.sum) begin
         $error("cell_sum: expected %0d, got %0d", want.sum, rsp_cell_sum);
         fail_count++;
      end
      if (rsp_cell_min !== want.min) begin
         $error("cell_min: expected %0d, got %0d", want.min, rsp_cell_min);
         fail_count++;
      end
      if (rsp_cell_max !== want.max) begin
         $error("cell_max: expected %0d, got %0d", want.max, rsp_cell_max);
         fail_count++;
      end
      checked_count++;
      if (want.count == COUNT_TOP || want.sum == SUM_HI || want.sum == SUM_LO)
         saturated_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (grid[i])
            grid[i] = EMPTY_CELL;
         stats_due.delete();
         fail_count      = 0;
         accum_count     = 0;
         checked_count   = 0;
         saturated_count = 0;
      end else begin
         // retire responses first: a read accepted at this edge cannot answer yet
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready)
            apply_request(req_operation, req_row_index, req_col_index, req_sample_value);
      end
      stats_pending = stats_due.size();
   end

endmodule

// File: test/tb_cell_count_sum_min_max_table.sv
`timescale 1ns / 1ps
// Top of the cell statistics table testbench: clock, reset, request and
// response drivers, verdict. Depends on ccsmt_pkg, the block and cell_stats_checker.
module tb_cell_count_sum_min_max_table;
   import ccsmt_pkg::*;

   localparam logic [OP_W-1:0]         OP_SPARE = 2'd3;
   localparam logic signed [VAL_W-1:0] VAL_HI   = EMPTY_MIN;
   localparam logic signed [VAL_W-1:0] VAL_LO   = EMPTY_MAX;
   localparam int RSP_HOLD_CYCLES  = 400;
   localparam int RANDOM_PER_PHASE = 300;
   // a short burst of extreme samples on two cells
   localparam int SAT_RUN          = 20;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation;
   logic [ROW_W-1:0]          req_row_index;
   logic [COL_W-1:0]          req_col_index;
   logic signed [VAL_W-1:0]   req_sample_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [COUNT_W-1:0]        rsp_cell_count;
   logic signed [SUM_W-1:0]   rsp_cell_sum;
   logic signed [VAL_W-1:0]   rsp_cell_min;
   logic signed [VAL_W-1:0]   rsp_cell_max;

   int req_idle_pct;
   int rsp_idle_pct;
   bit rsp_hold_wanted;
   int fail_count;
   int stats_pending;
   int accum_count;
   int checked_count;
   int saturated_count;

   cell_count_sum_min_max_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_cell_sum     (rsp_cell_sum),
      .rsp_cell_min     (rsp_cell_min),
      .rsp_cell_max     (rsp_cell_max)
   );

   cell_stats_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_cell_sum     (rsp_cell_sum),
      .rsp_cell_min     (rsp_cell_min),
      .rsp_cell_max     (rsp_cell_max),
      .fail_count       (fail_count),
      .stats_pending    (stats_pending),
      .accum_count      (accum_count),
      .checked_count    (checked_count),
      .saturated_count  (saturated_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("** cell_count_sum_min_max_table: FAILED **");
      $finish;
   end

   // Receiver: random back-pressure, plus one long hold on request.
   initial begin
      int held;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_wanted && held < RSP_HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
            held++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Enter and leave at a falling edge; valid stays high into the next request.
   task automatic offer(input logic [OP_W-1:0]         op,
                        input logic [ROW_W-1:0]        row,
                        input logic [COL_W-1:0]        col,
                        input logic signed [VAL_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_row_index    <= row;
      req_col_index    <= col;
      req_sample_value <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic random_request(output bit counted);
      logic [OP_W-1:0]         op;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] val;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 58)
         op = OP_ACCUM;
      else if (pick < 77)
         op = OP_READ;
      else if (pick < 95)
         op = OP_READ_CLR;
      else
         op = OP_SPARE;
      // mostly a few hot cells so that reads see real history
      if ($urandom_range(99) < 75) begin
         row = ROW_W'($urandom_range(3));
         col = COL_W'($urandom_range(3));
      end else begin
         row = ROW_W'($urandom);
         col = COL_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 10)
         val = VAL_HI;
      else if (pick < 20)
         val = VAL_LO;
      else if (pick < 55)
         val = (int'($urandom_range(2000)) - 1000) <<< 12;
      else
         val = $urandom;
      offer(op, row, col, val);
      counted = (op != OP_SPARE);
   endtask

   task automatic random_phase(input int items);
      int sent;
      bit counted;
      sent = 0;
      while (sent < items) begin
         random_request(counted);
         if (counted)
            sent++;
      end
   endtask

   initial begin
      int i;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_ACCUM;
      req_row_index    <= '0;
      req_col_index    <= '0;
      req_sample_value <= '0;
      req_idle_pct    = 20;
      rsp_idle_pct    = 20;
      rsp_hold_wanted = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty cell, extremes, grid corners, spare opcode, read then clear
      offer(OP_READ,     0,  0,  0);
      offer(OP_ACCUM,    0,  0,  VAL_HI);
      offer(OP_ACCUM,    0,  0,  VAL_LO);
      offer(OP_ACCUM,    0,  0,  0);
      offer(OP_READ,     0,  0,  0);
      offer(OP_ACCUM,    63, 63, -1);
      offer(OP_READ_CLR, 63, 63, 0);
      offer(OP_READ,     63, 63, 0);
      offer(OP_SPARE,    63, 63, VAL_HI);
      offer(OP_READ,     63, 63, 0);
      offer(OP_ACCUM,    0,  63, 32'sh0001_8000);
      offer(OP_ACCUM,    63, 0,  -32'sh0002_4000);
      offer(OP_READ_CLR, 0,  63, 0);
      offer(OP_READ_CLR, 63, 0,  0);
      // same cell back to back: each update must see the previous one
      req_idle_pct = 0;
      offer(OP_ACCUM,    5,  9,  1);
      offer(OP_ACCUM,    5,  9,  32'sh0001_0000);
      offer(OP_ACCUM,    5,  9,  -2);
      offer(OP_READ_CLR, 5,  9,  0);
      offer(OP_ACCUM,    5,  9,  7);
      offer(OP_READ,     5,  9,  0);
      offer(OP_READ_CLR, 0,  0,  0);
      offer(OP_READ,     0,  0,  0);

      // pile the largest samples on one cell and the smallest on another
      rsp_idle_pct = 0;
      for (i = 0; i < SAT_RUN; i++) begin
         offer(OP_ACCUM, 1, 2, VAL_HI);
         offer(OP_ACCUM, 2, 1, VAL_LO);
      end
      offer(OP_READ,     1, 2, 0);
      offer(OP_READ,     2, 1, 0);
      // min and max must still move after a run of extreme samples
      offer(OP_ACCUM,    1, 2, -5);
      offer(OP_ACCUM,    2, 1, 7);
      offer(OP_READ_CLR, 1, 2, 0);
      offer(OP_READ_CLR, 2, 1, 0);

      req_idle_pct = 29;
      rsp_idle_pct = 88;
      random_phase(RANDOM_PER_PHASE);
      req_idle_pct = 88;
      rsp_idle_pct = 29;
      random_phase(RANDOM_PER_PHASE);
      // hold responses back while requests keep coming, then run flat out
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      rsp_hold_wanted = 1'b1;
      random_phase(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      for (i = 0; i < 5000 && stats_pending != 0; i++)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Run: %0d accumulates applied, %0d cell reads checked, %0d on clamped cells.",
               accum_count, checked_count, saturated_count);
      $display("Grid corners, spare opcode, same-cell bursts and a %0d-cycle response hold.",
               RSP_HOLD_CYCLES);
      if (stats_pending != 0)
         $error("%0d reads never answered", stats_pending);
      if (fail_count == 0 && stats_pending == 0) begin
         $display("** cell_count_sum_min_max_table: PASSED **");
      end else begin
         $display("** cell_count_sum_min_max_table: FAILED **");
      end
      $finish;
   end

endmodule
